FILE: rtl/core/mhbt_pkg.sv
// shared types and constants for the mail html byte tagger
`timescale 1ns / 1ps

package mhbt_pkg;

    typedef enum logic [3:0] {
        PM_ANTICIPATE = 4'd0,
        PM_HEADER     = 4'd1,
        PM_HDR_END    = 4'd2,
        PM_COMMENT    = 4'd3,
        PM_TAG        = 4'd4,
        PM_ATTRS      = 4'd5,
        PM_SCRIPT     = 4'd6,
        PM_CDATA      = 4'd7,
        PM_TEXT       = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        TK_OTHER  = 2'd0,
        TK_SCRIPT = 2'd1,
        TK_STYLE  = 2'd2
    } tag_kind_t;

    localparam logic [2:0] CLS_PLAIN   = 3'd0;
    localparam logic [2:0] CLS_HEADER  = 3'd1;
    localparam logic [2:0] CLS_CDATA   = 3'd2;
    localparam logic [2:0] CLS_COMMENT = 3'd3;
    localparam logic [2:0] CLS_SCRIPT  = 3'd4;
    localparam logic [2:0] CLS_TAG     = 3'd5;
    localparam logic [2:0] CLS_ATTRS   = 3'd6;
    localparam logic [2:0] CLS_STYLE   = 3'd7;

    // suffix patterns, last character in the low byte
    localparam logic [55:0] PAT_OPEN_SCRIPT  = "<script";
    localparam logic [63:0] PAT_CLOSE_SCRIPT = "</script";
    localparam logic [63:0] PAT_CDATA_OPEN   = "<![CDATA";
    localparam logic [23:0] PAT_COMMENT_OPEN = "<!-";
    localparam logic [15:0] PAT_DASH_DASH    = "--";
    localparam logic [15:0] PAT_BRACKETS     = "]]";
    localparam logic [47:0] PAT_OPEN_STYLE   = "<style";

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_DASH   = 8'h2d;

    localparam int QUEUE_DEPTH = 2;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_zero;
        logic       is_nl;
        logic       is_lt;
        logic       is_gt;
        logic       is_ws;
        logic       is_lbrack;
        logic       is_dash;
        logic       end_dash_dash;
        logic       end_close_script;
        logic       end_open_script;
        logic       end_open_style;
        logic       end_cdata_open;
        logic       end_comment_open;
        logic       end_brackets;
    } token_t;

endpackage

FILE: rtl/core/mhbt_front.sv
// front end: accepts bytes, keeps the byte history and classifies each byte
`timescale 1ns / 1ps

module mhbt_front #(
    parameter int HISTORY_BYTES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              q_full,
    output logic              push,
    output mhbt_pkg::token_t  token
);

    logic [8*HISTORY_BYTES-1:0] hist_reg;
    logic [8*HISTORY_BYTES-1:0] hist_next;
    logic [63:0]                recent;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // most recent byte sits in the low byte
    assign recent    = hist_reg[63:0];
    assign hist_next = {hist_reg[8*HISTORY_BYTES-9:0], in_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (push)
        begin
            hist_reg <= hist_next;
        end
    end

    always_comb
    begin
        token.data      = in_byte;
        token.is_zero   = (in_byte == mhbt_pkg::CH_NUL);
        token.is_nl     = (in_byte == mhbt_pkg::CH_NL);
        token.is_lt     = (in_byte == mhbt_pkg::CH_LT);
        token.is_gt     = (in_byte == mhbt_pkg::CH_GT);
        token.is_ws     = (in_byte == mhbt_pkg::CH_SPACE)
                       || ((in_byte >= mhbt_pkg::CH_TAB) && (in_byte <= mhbt_pkg::CH_CR));
        token.is_lbrack = (in_byte == mhbt_pkg::CH_LBRACK);
        token.is_dash   = (in_byte == mhbt_pkg::CH_DASH);
        token.end_dash_dash    = (recent[15:0] == mhbt_pkg::PAT_DASH_DASH);
        token.end_close_script = (recent[63:0] == mhbt_pkg::PAT_CLOSE_SCRIPT);
        token.end_open_script  = (recent[55:0] == mhbt_pkg::PAT_OPEN_SCRIPT);
        token.end_open_style   = (recent[47:0] == mhbt_pkg::PAT_OPEN_STYLE);
        token.end_cdata_open   = (recent[63:0] == mhbt_pkg::PAT_CDATA_OPEN);
        token.end_comment_open = (recent[23:0] == mhbt_pkg::PAT_COMMENT_OPEN);
        token.end_brackets     = (recent[15:0] == mhbt_pkg::PAT_BRACKETS);
    end

endmodule

FILE: rtl/core/mhbt_queue.sv
// short token queue between the front end and the mode tracker
`timescale 1ns / 1ps

module mhbt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mhbt_pkg::token_t  push_token,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output mhbt_pkg::token_t  pop_token
);

    localparam int PTR_W = (mhbt_pkg::QUEUE_DEPTH > 1) ? $clog2(mhbt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mhbt_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(mhbt_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(mhbt_pkg::QUEUE_DEPTH - 1);

    mhbt_pkg::token_t entry_reg [mhbt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign empty     = (count_reg == '0);
    assign pop_token = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

FILE: rtl/core/mhbt_back.sv
// back end: parse mode and tag kind tracking, output register
`timescale 1ns / 1ps

module mhbt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  mhbt_pkg::token_t  token,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        byte_class,
    output logic [7:0]        out_byte
);

    mhbt_pkg::mode_t     mode_reg;
    mhbt_pkg::mode_t     mode_next;
    mhbt_pkg::mode_t     eff_mode;
    mhbt_pkg::tag_kind_t kind_reg;
    mhbt_pkg::tag_kind_t kind_next;
    logic                deferred;
    mhbt_pkg::mode_t     deferred_mode;
    logic [2:0]          cls;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] class_reg;
    logic [7:0] byte_reg;

    // output register frees up when empty or when its beat is taken
    assign pop            = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign byte_class     = class_reg;
    assign out_byte       = byte_reg;

    always_comb
    begin
        eff_mode      = mode_reg;
        kind_next     = kind_reg;
        deferred      = 1'b0;
        deferred_mode = mode_reg;
        cls           = mhbt_pkg::CLS_PLAIN;
        if (token.is_zero)
        begin
            deferred      = 1'b1;
            deferred_mode = mhbt_pkg::PM_ANTICIPATE;
        end
        else
        begin
            case (mode_reg)
                mhbt_pkg::PM_ANTICIPATE:
                begin
                    eff_mode = token.is_nl ? mhbt_pkg::PM_HDR_END : mhbt_pkg::PM_HEADER;
                end
                mhbt_pkg::PM_HEADER:
                begin
                    if (token.is_nl)
                    begin
                        deferred      = 1'b1;
                        deferred_mode = mhbt_pkg::PM_ANTICIPATE;
                    end
                end
                mhbt_pkg::PM_HDR_END:
                begin
                    if (token.is_lt)
                    begin
                        eff_mode  = mhbt_pkg::PM_TAG;
                        kind_next = mhbt_pkg::TK_OTHER;
                    end
                    else
                    begin
                        eff_mode = mhbt_pkg::PM_TEXT;
                    end
                end
                mhbt_pkg::PM_COMMENT:
                begin
                    if (token.is_gt && token.end_dash_dash)
                    begin
                        deferred      = 1'b1;
                        deferred_mode = mhbt_pkg::PM_TEXT;
                    end
                end
                mhbt_pkg::PM_SCRIPT:
                begin
                    if (token.is_gt && token.end_close_script)
                    begin
                        deferred      = 1'b1;
                        deferred_mode = mhbt_pkg::PM_TEXT;
                    end
                end
                mhbt_pkg::PM_TAG:
                begin
                    // tag name is settled at the first whitespace byte or the closing bracket
                    if (token.is_gt || token.is_ws)
                    begin
                        if (token.end_open_script)
                        begin
                            kind_next = mhbt_pkg::TK_SCRIPT;
                        end
                        else if (token.end_open_style)
                        begin
                            kind_next = mhbt_pkg::TK_STYLE;
                        end
                    end
                    if (token.is_gt)
                    begin
                        deferred      = 1'b1;
                        deferred_mode = (kind_next == mhbt_pkg::TK_SCRIPT)
                                      ? mhbt_pkg::PM_SCRIPT : mhbt_pkg::PM_TEXT;
                    end
                    else if (token.is_lbrack && token.end_cdata_open)
                    begin
                        deferred      = 1'b1;
                        deferred_mode = mhbt_pkg::PM_CDATA;
                    end
                    else if (token.is_dash && token.end_comment_open)
                    begin
                        deferred      = 1'b1;
                        deferred_mode = mhbt_pkg::PM_COMMENT;
                    end
                    else if (token.is_ws)
                    begin
                        eff_mode = mhbt_pkg::PM_ATTRS;
                    end
                end
                mhbt_pkg::PM_ATTRS:
                begin
                    if (token.is_gt)
                    begin
                        deferred      = 1'b1;
                        deferred_mode = (kind_reg == mhbt_pkg::TK_SCRIPT)
                                      ? mhbt_pkg::PM_SCRIPT : mhbt_pkg::PM_TEXT;
                    end
                end
                mhbt_pkg::PM_CDATA:
                begin
                    if (token.is_gt && token.end_brackets)
                    begin
                        eff_mode = mhbt_pkg::PM_TEXT;
                    end
                end
                mhbt_pkg::PM_TEXT:
                begin
                    if (token.is_lt)
                    begin
                        eff_mode  = mhbt_pkg::PM_TAG;
                        kind_next = mhbt_pkg::TK_OTHER;
                    end
                end
                default:
                begin
                    eff_mode = mode_reg;
                end
            endcase

            case (eff_mode)
                mhbt_pkg::PM_HEADER:  cls = mhbt_pkg::CLS_HEADER;
                mhbt_pkg::PM_CDATA:   cls = mhbt_pkg::CLS_CDATA;
                mhbt_pkg::PM_COMMENT: cls = mhbt_pkg::CLS_COMMENT;
                mhbt_pkg::PM_SCRIPT:  cls = mhbt_pkg::CLS_SCRIPT;
                mhbt_pkg::PM_TAG:     cls = mhbt_pkg::CLS_TAG;
                mhbt_pkg::PM_ATTRS:   cls = mhbt_pkg::CLS_ATTRS;
                mhbt_pkg::PM_TEXT:
                begin
                    cls = (kind_next == mhbt_pkg::TK_STYLE)
                        ? mhbt_pkg::CLS_STYLE : mhbt_pkg::CLS_PLAIN;
                end
                default:              cls = mhbt_pkg::CLS_PLAIN;
            endcase
        end
        mode_next = deferred ? deferred_mode : eff_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mhbt_pkg::PM_ANTICIPATE;
            kind_reg      <= mhbt_pkg::TK_OTHER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                mode_reg <= mode_next;
                kind_reg <= kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            class_reg <= cls;
            byte_reg  <= token.data;
        end
    end

endmodule

FILE: rtl/core/mail_html_byte_tagger_top.sv
// top level of the mail html byte tagger
`timescale 1ns / 1ps

// Tags every byte of a stream of mail documents (header, blank line, html body)
// with one of eight classes and echoes the byte alongside it. The block takes
// one byte per cycle and, while out_stall is low, sustains one result beat per
// cycle. An accepted byte is first written into the queue entry register, and
// its class and byte are then presented from the back end's output register.
// The front end holds the last HISTORY_BYTES bytes and does the suffix compares,
// a two-entry queue carries classified bytes to the mode tracker, and the mode
// and tag kind update once per byte in the back end, which feeds an output
// register. A zero byte ends a document and gets the plain class.

module mail_html_byte_tagger_top #(
    parameter int HISTORY_BYTES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] byte_class,
    output logic [7:0] out_byte
);

    mhbt_pkg::token_t front_token;
    mhbt_pkg::token_t back_token;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;

    mhbt_front #(
        .HISTORY_BYTES(HISTORY_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (q_push),
        .token    (front_token)
    );

    mhbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (front_token),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .pop_token  (back_token)
    );

    mhbt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .token      (back_token),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_class (byte_class),
        .out_byte   (out_byte)
    );

endmodule

FILE: dv/mail_html_byte_tagger_top_test.sv
// self-checking testbench for the mail html byte tagger top level
`timescale 1ns / 1ps

module mail_html_byte_tagger_top_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] data;
    } tagged_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] byte_class;
    logic [7:0] out_byte;

    // tagger state as predicted from the accepted beats
    mhbt_pkg::mode_t     track_mode = mhbt_pkg::PM_ANTICIPATE;
    mhbt_pkg::tag_kind_t track_kind = mhbt_pkg::TK_OTHER;
    logic [7:0] recent [8] = '{default: 8'h00};

    logic [7:0]   byte_backlog_q [$];
    tagged_byte_t class_due_q [$];

    int send_idle_pct = 22;
    int recv_idle_pct = 69;
    int items_queued = 0;
    int beats_in = 0;
    int results_checked = 0;
    int docs_built = 0;
    int errors = 0;
    int cycles = 0;

    string tag_names [8] = '{"p", "div", "a", "br", "span", "scripts", "styles", "Script"};
    string fragments [10] = '{"<scrip", "</scrip>", "<!-x", "<![CDAT[", "]>", "->",
                              "<style", "<!", "<script", "<style>"};
    logic [7:0] blanks [6] = '{8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20};

    mail_html_byte_tagger_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_class (byte_class),
        .out_byte   (out_byte)
    );

    always #6 clk = ~clk;

    // true when the bytes before the current one end in pat (last char in low byte)
    function automatic logic ends_in(input logic [63:0] pat, input int len);
        for (int i = 0; i < len; i++)
        begin
            if (recent[i] != pat[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] predict_class(input logic [7:0] c);
        mhbt_pkg::mode_t cur;
        mhbt_pkg::mode_t nxt;
        logic [2:0]      cls;
        logic            ws;
        cur = track_mode;
        nxt = track_mode;
        ws  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
        if (c == mhbt_pkg::CH_NUL)
        begin
            cls = mhbt_pkg::CLS_PLAIN;
            nxt = mhbt_pkg::PM_ANTICIPATE;
        end
        else
        begin
            case (cur)
                mhbt_pkg::PM_ANTICIPATE:
                    cur = (c == mhbt_pkg::CH_NL) ? mhbt_pkg::PM_HDR_END : mhbt_pkg::PM_HEADER;
                mhbt_pkg::PM_HEADER:
                    if (c == mhbt_pkg::CH_NL)
                        nxt = mhbt_pkg::PM_ANTICIPATE;
                mhbt_pkg::PM_HDR_END:
                    if (c == mhbt_pkg::CH_LT)
                    begin
                        cur = mhbt_pkg::PM_TAG;
                        track_kind = mhbt_pkg::TK_OTHER;
                    end
                    else
                        cur = mhbt_pkg::PM_TEXT;
                mhbt_pkg::PM_COMMENT:
                    if (c == mhbt_pkg::CH_GT && ends_in(64'(mhbt_pkg::PAT_DASH_DASH), 2))
                        nxt = mhbt_pkg::PM_TEXT;
                mhbt_pkg::PM_SCRIPT:
                    if (c == mhbt_pkg::CH_GT && ends_in(mhbt_pkg::PAT_CLOSE_SCRIPT, 8))
                        nxt = mhbt_pkg::PM_TEXT;
                mhbt_pkg::PM_TAG:
                begin
                    if (c == mhbt_pkg::CH_GT || ws)
                    begin
                        if (ends_in(64'(mhbt_pkg::PAT_OPEN_SCRIPT), 7))
                            track_kind = mhbt_pkg::TK_SCRIPT;
                        else if (ends_in(64'(mhbt_pkg::PAT_OPEN_STYLE), 6))
                            track_kind = mhbt_pkg::TK_STYLE;
                    end
                    if (c == mhbt_pkg::CH_GT)
                        nxt = (track_kind == mhbt_pkg::TK_SCRIPT)
                            ? mhbt_pkg::PM_SCRIPT : mhbt_pkg::PM_TEXT;
                    else if (c == mhbt_pkg::CH_LBRACK && ends_in(mhbt_pkg::PAT_CDATA_OPEN, 8))
                        nxt = mhbt_pkg::PM_CDATA;
                    else if (c == mhbt_pkg::CH_DASH
                             && ends_in(64'(mhbt_pkg::PAT_COMMENT_OPEN), 3))
                        nxt = mhbt_pkg::PM_COMMENT;
                    else if (ws)
                        cur = mhbt_pkg::PM_ATTRS;
                end
                mhbt_pkg::PM_ATTRS:
                    if (c == mhbt_pkg::CH_GT)
                        nxt = (track_kind == mhbt_pkg::TK_SCRIPT)
                            ? mhbt_pkg::PM_SCRIPT : mhbt_pkg::PM_TEXT;
                mhbt_pkg::PM_CDATA:
                    if (c == mhbt_pkg::CH_GT && ends_in(64'(mhbt_pkg::PAT_BRACKETS), 2))
                        cur = mhbt_pkg::PM_TEXT;
                mhbt_pkg::PM_TEXT:
                    if (c == mhbt_pkg::CH_LT)
                    begin
                        cur = mhbt_pkg::PM_TAG;
                        track_kind = mhbt_pkg::TK_OTHER;
                    end
                default: ;
            endcase
            // an immediate change also carries into the next byte
            if (nxt == track_mode && cur != track_mode)
                nxt = cur;
            case (cur)
                mhbt_pkg::PM_HEADER:  cls = mhbt_pkg::CLS_HEADER;
                mhbt_pkg::PM_CDATA:   cls = mhbt_pkg::CLS_CDATA;
                mhbt_pkg::PM_COMMENT: cls = mhbt_pkg::CLS_COMMENT;
                mhbt_pkg::PM_SCRIPT:  cls = mhbt_pkg::CLS_SCRIPT;
                mhbt_pkg::PM_TAG:     cls = mhbt_pkg::CLS_TAG;
                mhbt_pkg::PM_ATTRS:   cls = mhbt_pkg::CLS_ATTRS;
                mhbt_pkg::PM_TEXT:
                    cls = (track_kind == mhbt_pkg::TK_STYLE)
                        ? mhbt_pkg::CLS_STYLE : mhbt_pkg::CLS_PLAIN;
                default:              cls = mhbt_pkg::CLS_PLAIN;
            endcase
        end
        for (int i = 7; i > 0; i--)
            recent[i] = recent[i-1];
        recent[0] = c;
        track_mode = nxt;
        return cls;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        byte_backlog_q.push_back(b);
        items_queued++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_blank();
        push_byte(blanks[$urandom_range(5)]);
    endtask

    // n random nonzero bytes, avoiding one that would end the current construct
    task automatic push_filler(input int n, input logic [7:0] ban);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(1, 255));
            while (b == ban)
                b = 8'($urandom_range(1, 255));
            push_byte(b);
        end
    endtask

    task automatic push_open_tag(input string name);
        push_str({"<", name});
        if ($urandom_range(1))
        begin
            push_blank();
            push_filler($urandom_range(0, 6), mhbt_pkg::CH_GT);
        end
        push_byte(mhbt_pkg::CH_GT);
    endtask

    task automatic build_document();
        int lines;
        int parts;
        docs_built++;
        if ($urandom_range(99) < 15)
        begin
            // noise run, zeros included
            repeat ($urandom_range(1, 24))
                push_byte(8'($urandom_range(255)));
            return;
        end
        lines = $urandom_range(3);
        repeat (lines)
        begin
            push_filler($urandom_range(1, 12), mhbt_pkg::CH_NL);
            push_byte(mhbt_pkg::CH_NL);
        end
        push_byte(mhbt_pkg::CH_NL);
        parts = $urandom_range(2, 8);
        repeat (parts)
        begin
            case ($urandom_range(9))
                0, 1: push_filler($urandom_range(1, 12), mhbt_pkg::CH_LT);
                2: push_open_tag(tag_names[$urandom_range(7)]);
                3:
                begin
                    push_open_tag("script");
                    push_filler($urandom_range(0, 10), mhbt_pkg::CH_LT);
                    push_str("</script>");
                end
                4:
                begin
                    push_open_tag("style");
                    push_filler($urandom_range(0, 10), mhbt_pkg::CH_LT);
                    push_str("</style>");
                end
                5:
                begin
                    push_str("<!--");
                    push_filler($urandom_range(0, 8), mhbt_pkg::CH_DASH);
                    push_str("-->");
                end
                6:
                begin
                    push_str("<![CDATA[");
                    push_filler($urandom_range(0, 8), 8'h5d);
                    push_str("]]>");
                end
                7: push_str(fragments[$urandom_range(9)]);
                8: push_blank();
                default: push_byte(8'($urandom_range(255)));
            endcase
        end
        push_byte(mhbt_pkg::CH_NUL);
    endtask

    // the sender holds off here until every expected result has come back
    task automatic wait_drained();
        @(negedge clk);
        while (byte_backlog_q.size() != 0 || in_valid || class_due_q.size() != 0)
            @(negedge clk);
    endtask

    // driver: a new beat only once the previous one has gone
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                class_due_q.push_back(tagged_byte_t'{predict_class(in_byte), in_byte});
                beats_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_byte  <= byte_backlog_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (class_due_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, byte_class %0d out_byte 0x%02h",
                         $time, byte_class, out_byte);
                errors++;
            end
            else
            begin
                if (class_due_q[0].cls !== byte_class)
                begin
                    $display("%0t: byte_class mismatch, expected %0d actual %0d",
                             $time, class_due_q[0].cls, byte_class);
                    errors++;
                end
                if (class_due_q[0].data !== out_byte)
                begin
                    $display("%0t: out_byte mismatch, expected 0x%02h actual 0x%02h",
                             $time, class_due_q[0].data, out_byte);
                    errors++;
                end
                void'(class_due_q.pop_front());
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still due", $time, class_due_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: max byte as first header byte, header newline, separator line,
        // empty comment, text whitespace, empty cdata, whitespace in a tag, boundary
        push_byte(8'hff);
        push_str("\n\n<!-->\t<![CDATA[]]><b\v>");
        push_byte(mhbt_pkg::CH_NUL);
        wait_drained();

        while (items_queued < 520)
            build_document();
        wait_drained();

        send_idle_pct = 69;
        recv_idle_pct = 22;
        while (items_queued < 1040)
            build_document();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_queued < 1550)
            build_document();
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (class_due_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, class_due_q.size());
            errors++;
        end

        $display("classified %0d bytes in %0d documents or noise runs, %0d results checked",
                 beats_in, docs_built, results_checked);
        $display("stall mixes: sender-light, receiver-light and back to back, %0d errors",
                 errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mhbt_pkg.sv
rtl/core/mhbt_front.sv
rtl/core/mhbt_queue.sv
rtl/core/mhbt_back.sv
rtl/core/mail_html_byte_tagger_top.sv
dv/mail_html_byte_tagger_top_test.sv
